FILE: src/i2cme_pkg.sv
// Shared types and constants for the i2c master bit engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2cme_pkg;

   // half period register
   localparam int HalfPeriodW = 10;
   localparam logic [HalfPeriodW-1:0] HalfPeriodReset = 10'd4;

   // bits per byte, counted by the bit index
   localparam logic [3:0] BitsPerByte = 4'd8;

   // command codes as carried in the kind field
   typedef enum logic [2:0] {
      OP_START   = 3'd0,
      OP_STOP    = 3'd1,
      OP_RESTART = 3'd2,
      OP_WRITE   = 3'd3,
      OP_READ    = 3'd4
   } op_type;

   // engine phases
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_SEQ_A    = 4'd1,
      PH_SEQ_B    = 4'd2,
      PH_SEQ_C    = 4'd3,
      PH_BIT_LOW  = 4'd4,
      PH_BIT_HIGH = 4'd5,
      PH_ACK_LOW  = 4'd6,
      PH_ACK_HIGH = 4'd7,
      PH_RA1      = 4'd8,
      PH_RA2      = 4'd9,
      PH_RA3      = 4'd10,
      PH_RA4      = 4'd11,
      PH_RA5      = 4'd12
   } phase_type;

   // one tick as presented on the input side
   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] kind;
      logic [7:0] write_data;
      logic       send_ack;
      logic       sda_in;
   } req_item_type;

   // one result beat
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       nack;
   } rsp_item_type;

   // classified tick passed from front to back
   typedef struct packed {
      logic       go;
      op_type     op;
      logic [7:0] write_data;
      logic       send_ack;
      logic       sda_in;
   } tick_type;

endpackage

FILE: src/i2cme_front.sv
// Front end: decodes each incoming tick and holds it in a two-entry queue.
// Depends on i2cme_pkg.
`timescale 1ns / 1ps

module i2cme_front
   import i2cme_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_data,
   output logic         tick_valid,
   output tick_type     tick_data,
   input  logic         tick_take
);

   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   tick_type   slot_ff [2];
   tick_type   classified;
   logic       push_ok;
   logic       pop_ok;

   // decode: a command counts only with a known kind
   always_comb begin
      classified.go         = req_data.cmd_valid && (req_data.kind <= 3'(OP_READ));
      classified.op         = op_type'(req_data.kind);
      classified.write_data = req_data.write_data;
      classified.send_ack   = req_data.send_ack;
      classified.sda_in     = req_data.sda_in;
   end

   // queue handshake
   assign full       = (count_ff == 2'd2);
   assign tick_valid = (count_ff != 2'd0);
   assign tick_data  = slot_ff[rd_ptr_ff];
   assign push_ok    = push & ~full;
   assign pop_ok     = tick_take & tick_valid;

   always_comb begin
      count_in  = 2'(count_ff + {1'b0, push_ok} - {1'b0, pop_ok});
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

FILE: src/i2cme_back.sv
// Back end: runs the bus phase sequencer one tick per step and queues results.
// Depends on i2cme_pkg.
`timescale 1ns / 1ps

module i2cme_back
   import i2cme_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [HalfPeriodW-1:0] csr_wr_data,
   input  logic                   tick_valid,
   input  tick_type               tick_data,
   output logic                   tick_take,
   output logic                   empty,
   input  logic                   pop,
   output rsp_item_type           rsp_data
);

   // engine state
   logic [HalfPeriodW-1:0] half_ff;
   phase_type              phase_ff, phase_in;
   op_type                 op_ff, op_in;
   logic [HalfPeriodW-1:0] cnt_ff, cnt_in;
   logic [3:0]             bit_ff, bit_in;
   logic [7:0]             shift_ff, shift_in;
   logic [7:0]             recv_ff, recv_in;
   logic                   nack_ff, nack_in;
   logic                   ack_ff, ack_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;

   // step helpers
   logic [HalfPeriodW-1:0] half_eff;
   logic [HalfPeriodW-1:0] cnt_inc;
   logic [3:0]             bit_inc;
   logic [7:0]             shifted;
   logic                   done;
   logic                   step;
   rsp_item_type           result;

   // result queue
   logic [1:0]   ocount_ff, ocount_in;
   logic         owr_ff, ord_ff;
   rsp_item_type oslot_ff [2];
   logic         out_full;
   logic         pop_ok;

   assign out_full  = (ocount_ff == 2'd2);
   assign step      = tick_valid & ~out_full;
   assign tick_take = step;

   // a zero half period behaves as one
   assign half_eff = (half_ff == '0) ? HalfPeriodW'(1) : half_ff;
   assign cnt_inc  = cnt_ff + HalfPeriodW'(1);
   assign bit_inc  = bit_ff + 4'd1;
   assign shifted  = {shift_ff[6:0], (op_ff == OP_READ) ? tick_data.sda_in : 1'b0};

   // next state of the sequencer for one tick
   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      recv_in  = recv_ff;
      nack_in  = nack_ff;
      ack_in   = ack_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      done     = 1'b0;
      if (phase_ff == PH_IDLE) begin
         // launch a new command
         if (tick_data.go) begin
            op_in  = tick_data.op;
            cnt_in = '0;
            if (tick_data.op == OP_WRITE || tick_data.op == OP_READ) begin
               bit_in   = 4'd0;
               scl_in   = 1'b0;
               phase_in = PH_BIT_LOW;
               if (tick_data.op == OP_WRITE) begin
                  shift_in = tick_data.write_data;
                  sda_in   = tick_data.write_data[7];
               end else begin
                  shift_in = 8'd0;
                  ack_in   = tick_data.send_ack;
                  sda_in   = 1'b1;
               end
            end else begin
               sda_in   = (tick_data.op != OP_STOP);
               phase_in = PH_SEQ_A;
            end
         end
      end else if (cnt_inc >= half_eff || cnt_inc == '0) begin
         // half period over: move to the next phase
         cnt_in = '0;
         unique case (phase_ff)
            PH_SEQ_A: begin
               scl_in   = 1'b1;
               phase_in = PH_SEQ_B;
            end
            PH_SEQ_B: begin
               sda_in   = (op_ff == OP_STOP);
               phase_in = PH_SEQ_C;
            end
            PH_SEQ_C: begin
               if (op_ff == OP_START) begin
                  scl_in = 1'b0;
               end
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            PH_BIT_LOW: begin
               scl_in   = 1'b1;
               phase_in = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
               scl_in   = 1'b0;
               bit_in   = bit_inc;
               shift_in = shifted;
               if (bit_inc >= BitsPerByte) begin
                  sda_in = 1'b1;
                  if (op_ff == OP_READ) begin
                     recv_in  = shifted;
                     phase_in = PH_RA1;
                  end else begin
                     phase_in = PH_ACK_LOW;
                  end
               end else begin
                  sda_in   = (op_ff == OP_READ) ? 1'b1 : shifted[7];
                  phase_in = PH_BIT_LOW;
               end
            end
            PH_ACK_LOW: begin
               scl_in   = 1'b1;
               phase_in = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
               nack_in  = tick_data.sda_in;
               scl_in   = 1'b0;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            PH_RA1: begin
               sda_in   = ~ack_ff;
               phase_in = PH_RA2;
            end
            PH_RA2: begin
               scl_in   = 1'b1;
               phase_in = PH_RA3;
            end
            PH_RA3: begin
               scl_in   = 1'b0;
               phase_in = PH_RA4;
            end
            PH_RA4: begin
               sda_in   = 1'b1;
               phase_in = PH_RA5;
            end
            PH_RA5: begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end else begin
         cnt_in = cnt_inc;
      end
   end

   // result of this tick
   always_comb begin
      result.scl_out   = scl_in;
      result.sda_out   = sda_in;
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.read_data = recv_in;
      result.nack      = nack_in;
   end

   // half period register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HalfPeriodReset;
      end else if (csr_wr_en) begin
         half_ff <= csr_wr_data;
      end
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= OP_START;
         cnt_ff   <= '0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         recv_ff  <= 8'd0;
         nack_ff  <= 1'b0;
         ack_ff   <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
      end else if (step) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         recv_ff  <= recv_in;
         nack_ff  <= nack_in;
         ack_ff   <= ack_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
      end
   end

   // result queue handshake
   assign empty    = (ocount_ff == 2'd0);
   assign rsp_data = oslot_ff[ord_ff];
   assign pop_ok   = pop & ~empty;
   assign ocount_in = 2'(ocount_ff + {1'b0, step} - {1'b0, pop_ok});

   always_ff @(posedge clock) begin
      if (reset) begin
         ocount_ff <= 2'd0;
         owr_ff    <= 1'b0;
         ord_ff    <= 1'b0;
      end else begin
         ocount_ff <= ocount_in;
         owr_ff    <= owr_ff ^ step;
         ord_ff    <= ord_ff ^ pop_ok;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (step) begin
         oslot_ff[owr_ff] <= result;
      end
   end

endmodule

FILE: src/i2c_master_bit_engine_core.sv
// Top level of the i2c master bit engine: front decoder/queue and back sequencer.
// Depends on i2cme_pkg, i2cme_front and i2cme_back.
`timescale 1ns / 1ps

// Each pushed beat is one time tick of the engine and yields exactly one result
// beat. The engine sustains one tick per clock: the phase sequencer in the back
// end takes one step per cycle, so a tick can be pushed every cycle while results
// are popped every cycle. An accepted tick is registered in the input queue; the
// sequencer step that takes it registers its result into the result queue, from
// which it shows on the result ports and can be popped.
// Both queues hold two beats, so either side may stall on its own; full rises
// only when the result side has stalled long enough to back the queues up.
// The half period register may be written at any time the engine has no ticks
// in flight; a value of zero acts as one.

module i2c_master_bit_engine_core
   import i2cme_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  req_item_type           req_data,
   output logic                   empty,
   input  logic                   pop,
   output rsp_item_type           rsp_data,
   input  logic                   csr_wr_en,
   input  logic [HalfPeriodW-1:0] csr_wr_data
);

   logic     tick_valid;
   logic     tick_take;
   tick_type tick_data;

   // decode and buffer incoming ticks
   i2cme_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .tick_valid (tick_valid),
      .tick_data  (tick_data),
      .tick_take  (tick_take)
   );

   // run the bus sequencer and queue results
   i2cme_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .tick_valid  (tick_valid),
      .tick_data   (tick_data),
      .tick_take   (tick_take),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: src/i2cme_checker.sv
// Port-level checks for the i2c master bit engine, bound to the top level.
// Depends on i2cme_pkg and i2c_master_bit_engine_core.
`timescale 1ns / 1ps

module i2cme_checker
   import i2cme_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         full,
   input logic         empty,
   input logic         pop,
   input rsp_item_type rsp_data
);

   // reset leaves no result waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result waiting after reset");

   // a command finishes on a beat that is no longer busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_data.done_res && rsp_data.busy_res))
      else $error("done beat still flagged busy");

   // the input side can only back up while results are waiting
   a_full_needs_results: assert property (@(posedge clock) disable iff (reset)
      empty |-> !full)
      else $error("full with no result waiting");

   // a waiting result holds until it is popped
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

endmodule

bind i2c_master_bit_engine_core i2cme_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
